// ===== design/sf4c_pkg.sv =====
`default_nettype none

package sf4c_pkg;

	// grid geometry
	localparam int GRID_W = 64;
	localparam int GRID_H = 64;
	localparam int COL_W  = $clog2(GRID_W);
	localparam int ROW_W  = $clog2(GRID_H);
	localparam int IDX_W  = COL_W + ROW_W;
	localparam int SIZE_W = 7;

	// pending container
	localparam int CONT_DEPTH = 16384;
	localparam int PTR_W      = $clog2(CONT_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// commands
	localparam logic [1:0] CMD_WALL  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_STARTED = 3'd0;
	localparam logic [2:0] STAT_FILLED  = 3'd1;
	localparam logic [2:0] STAT_REVISIT = 3'd2;
	localparam logic [2:0] STAT_DONE    = 3'd3;
	localparam logic [2:0] STAT_OUTSIDE = 3'd4;
	localparam logic [2:0] STAT_OVF     = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_BOX_WIDTH  = 3'd2;
	localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FILL_ORDER = 3'd4;

	typedef struct packed {
		logic             clear;
		logic             push;
		logic             pop;
		logic             lifo;
		logic [IDX_W-1:0] push_idx;
	} cont_ctrl_t;

	typedef struct packed {
		logic empty;
		logic overflow;
	} cont_stat_t;

endpackage

`default_nettype wire

// ===== design/seed_fill_4_connected.sv =====
// Four-connected seed fill over a 64 x 64 box-relative wall bitmap.
//
// Input channel: drive command and its fields with start high; the word is
// taken at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with status, pixel_x and pixel_y.
// The receiver cannot stall: the word is gone after that cycle.
// Configuration: APB-style write port, registers at byte addresses 0, 4, 8,
// 12, 16 (origin_x, origin_y, box_width, box_height, fill_order); write
// them only while the block is idle. pready is tied high.
//
// Reports per command: a wall write gives none; a start gives started, or
//   outside for a seed outside the box; an advance gives filled or revisit,
//   or done or overflow when the container is empty.
// The next word can be taken in the first cycle with busy low. A popping
// advance is paced by the single row read port of the wall and visited maps
// (three rows read in turn) and by the single write port of the pending
// container (four push slots, one a cycle).
// Reset: walls and visited marks read as clear through per-row valid bits,
// so there is no clearing pass, and the container starts empty. A start
// with a seed inside the box clears the visited rows and the container.
`default_nettype none

module seed_fill_4_connected (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  cell_col,
	input  wire logic [5:0]  cell_row,
	input  wire logic        wall_bit,
	input  wire logic signed [15:0] seed_x,
	input  wire logic signed [15:0] seed_y,
	// result channel
	output logic             done,
	output logic [2:0]       status,
	output logic signed [16:0] pixel_x,
	output logic signed [16:0] pixel_y,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sf4c_pkg::*;

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRD   = 4'd1;  // read wall row
	localparam logic [3:0] S_WWR   = 4'd2;  // write wall row back
	localparam logic [3:0] S_SCHK  = 4'd3;  // seed bounds check
	localparam logic [3:0] S_SPUSH = 4'd4;  // push seed
	localparam logic [3:0] S_APOP  = 4'd5;  // pop one entry
	localparam logic [3:0] S_AIDX  = 4'd6;  // entry ready, read own row
	localparam logic [3:0] S_AR0   = 4'd7;  // own row in, read row below
	localparam logic [3:0] S_AR1   = 4'd8;  // row below in, read row above
	localparam logic [3:0] S_AR2   = 4'd9;  // row above in
	localparam logic [3:0] S_PUSH  = 4'd10; // one neighbor slot per cycle

	// configuration registers
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [SIZE_W-1:0]  box_width_q;
	logic [SIZE_W-1:0]  box_height_q;
	logic               fill_order_q;

	logic [3:0]         state_q, state_d;

	// latched command word
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               wall_bit_q;
	logic signed [15:0] seed_x_q;
	logic signed [15:0] seed_y_q;
	logic [IDX_W-1:0]   seed_idx_q;

	// neighbor candidates: +x, +y, -x, -y
	logic [3:0]         cand_q, cand_d;
	logic [1:0]         sel_q;

	// result register
	logic               done_q;
	logic [2:0]         status_q;
	logic signed [16:0] pixel_x_q;
	logic signed [16:0] pixel_y_q;

	// row maps
	logic [GRID_W-1:0]  vis_mem  [GRID_H];
	logic [GRID_W-1:0]  wall_mem [GRID_H];
	logic [GRID_H-1:0]  vis_vld_q;
	logic [GRID_H-1:0]  wall_vld_q;
	logic [GRID_W-1:0]  vis_rd_q;
	logic [GRID_W-1:0]  wall_rd_q;
	logic               vis_rv_q;
	logic               wall_rv_q;
	logic [GRID_W-1:0]  vis_row;
	logic [GRID_W-1:0]  wall_row;
	logic [ROW_W-1:0]   row_ra;
	logic               vis_we;
	logic               vis_clr;
	logic [GRID_W-1:0]  vis_wd;
	logic               wall_we;
	logic [GRID_W-1:0]  wall_wd;

	// container
	cont_ctrl_t         cctl;
	cont_stat_t         cstat;
	logic [IDX_W-1:0]   pop_idx;
	logic [COL_W-1:0]   cur_col;
	logic [ROW_W-1:0]   cur_row;

	// effective box and seed check
	logic [SIZE_W-1:0]  w_eff;
	logic [SIZE_W-1:0]  h_eff;
	logic signed [16:0] rel_x;
	logic signed [16:0] rel_y;
	logic               seed_out;

	// result staging
	logic               res_en;
	logic [2:0]         res_stat;
	logic signed [16:0] res_px;
	logic signed [16:0] res_py;

	logic               accept;
	logic               cfg_wr;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	assign cur_col = pop_idx[COL_W-1:0];
	assign cur_row = pop_idx[IDX_W-1:COL_W];

	// clamp box size to 1 .. grid
	always_comb begin
		if (box_width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (box_width_q > SIZE_W'(GRID_W)) begin
			w_eff = SIZE_W'(GRID_W);
		end else begin
			w_eff = box_width_q;
		end
		if (box_height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (box_height_q > SIZE_W'(GRID_H)) begin
			h_eff = SIZE_W'(GRID_H);
		end else begin
			h_eff = box_height_q;
		end
	end

	assign rel_x    = {seed_x_q[15], seed_x_q} - {origin_x_q[15], origin_x_q};
	assign rel_y    = {seed_y_q[15], seed_y_q} - {origin_y_q[15], origin_y_q};
	assign seed_out = rel_x[16] || rel_y[16]
		|| (rel_x[15:0] >= {{(16-SIZE_W){1'b0}}, w_eff})
		|| (rel_y[15:0] >= {{(16-SIZE_W){1'b0}}, h_eff});

	// a row that was never written since its clear reads as zero
	assign vis_row  = vis_rv_q  ? vis_rd_q  : '0;
	assign wall_row = wall_rv_q ? wall_rd_q : '0;

	always_comb begin
		wall_wd        = wall_row;
		wall_wd[col_q] = wall_bit_q;
	end

	assign vis_wd = vis_row | (GRID_W'(1) << cur_col);

	// sequencer
	always_comb begin
		state_d       = state_q;
		cand_d        = cand_q;
		cctl.clear    = 1'b0;
		cctl.push     = 1'b0;
		cctl.pop      = 1'b0;
		cctl.lifo     = !fill_order_q;
		cctl.push_idx = seed_idx_q;
		vis_we        = 1'b0;
		vis_clr       = 1'b0;
		wall_we       = 1'b0;
		row_ra        = cur_row;
		res_en        = 1'b0;
		res_stat      = STAT_STARTED;
		res_px        = '0;
		res_py        = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_WALL:  state_d = S_WRD;
						CMD_START: state_d = S_SCHK;
						CMD_STEP:  state_d = S_APOP;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_WRD: begin
				row_ra  = row_q;
				state_d = S_WWR;
			end
			S_WWR: begin
				wall_we = 1'b1;
				state_d = S_IDLE;
			end
			S_SCHK: begin
				if (seed_out) begin
					res_en   = 1'b1;
					res_stat = STAT_OUTSIDE;
					state_d  = S_IDLE;
				end else begin
					cctl.clear = 1'b1;
					vis_clr    = 1'b1;
					state_d    = S_SPUSH;
				end
			end
			S_SPUSH: begin
				cctl.push = 1'b1;
				res_en    = 1'b1;
				res_stat  = STAT_STARTED;
				state_d   = S_IDLE;
			end
			S_APOP: begin
				if (cstat.empty) begin
					res_en   = 1'b1;
					res_stat = cstat.overflow ? STAT_OVF : STAT_DONE;
					state_d  = S_IDLE;
				end else begin
					cctl.pop = 1'b1;
					state_d  = S_AIDX;
				end
			end
			S_AIDX: begin
				row_ra  = cur_row;
				state_d = S_AR0;
			end
			S_AR0: begin
				// own row: mark, report, judge the two side neighbors
				row_ra = cur_row + ROW_W'(1);
				vis_we = 1'b1;
				res_en = 1'b1;
				if (!vis_row[cur_col]) begin
					res_stat = STAT_FILLED;
					res_px   = {origin_x_q[15], origin_x_q}
						+ 17'({{(17-COL_W){1'b0}}, cur_col});
					res_py   = {origin_y_q[15], origin_y_q}
						+ 17'({{(17-ROW_W){1'b0}}, cur_row});
				end else begin
					res_stat = STAT_REVISIT;
				end
				cand_d[0] = (({1'b0, cur_col} + SIZE_W'(1)) < w_eff)
					&& !vis_row[cur_col + COL_W'(1)]
					&& !wall_row[cur_col + COL_W'(1)];
				cand_d[2] = (cur_col != '0)
					&& !vis_row[cur_col - COL_W'(1)]
					&& !wall_row[cur_col - COL_W'(1)];
				state_d = S_AR1;
			end
			S_AR1: begin
				row_ra    = cur_row - ROW_W'(1);
				cand_d[1] = (({1'b0, cur_row} + SIZE_W'(1)) < h_eff)
					&& !vis_row[cur_col] && !wall_row[cur_col];
				state_d   = S_AR2;
			end
			S_AR2: begin
				cand_d[3] = (cur_row != '0)
					&& !vis_row[cur_col] && !wall_row[cur_col];
				state_d   = S_PUSH;
			end
			S_PUSH: begin
				cctl.push = cand_q[sel_q];
				case (sel_q)
					2'd0:    cctl.push_idx = {cur_row, cur_col + COL_W'(1)};
					2'd1:    cctl.push_idx = {cur_row + ROW_W'(1), cur_col};
					2'd2:    cctl.push_idx = {cur_row, cur_col - COL_W'(1)};
					default: cctl.push_idx = {cur_row - ROW_W'(1), cur_col};
				endcase
				if (sel_q == 2'd3) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	sf4c_cont u_cont (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cctl),
		.pop_idx (pop_idx),
		.stat    (cstat)
	);

	// row memories, one read and one write port each
	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[cur_row] <= vis_wd;
		end
		if (wall_we) begin
			wall_mem[row_q] <= wall_wd;
		end
		vis_rd_q  <= vis_mem[row_ra];
		wall_rd_q <= wall_mem[row_ra];
		vis_rv_q  <= vis_vld_q[row_ra];
		wall_rv_q <= wall_vld_q[row_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_vld_q  <= '0;
			wall_vld_q <= '0;
		end else begin
			if (vis_clr) begin
				vis_vld_q <= '0;
			end else if (vis_we) begin
				vis_vld_q[cur_row] <= 1'b1;
			end
			if (wall_we) begin
				wall_vld_q[row_q] <= 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= '0;
			cand_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cand_q  <= cand_d;
			done_q  <= res_en;
			if (state_q == S_PUSH) begin
				sel_q <= sel_q + 2'd1;
			end else begin
				sel_q <= '0;
			end
		end
	end

	// hold the command word and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q      <= cell_col;
			row_q      <= cell_row;
			wall_bit_q <= wall_bit;
			seed_x_q   <= seed_x;
			seed_y_q   <= seed_y;
		end
		if (state_q == S_SCHK) begin
			seed_idx_q <= {rel_y[ROW_W-1:0], rel_x[COL_W-1:0]};
		end
		if (res_en) begin
			status_q  <= res_stat;
			pixel_x_q <= res_px;
			pixel_y_q <= res_py;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			box_width_q  <= SIZE_W'(GRID_W);
			box_height_q <= SIZE_W'(GRID_H);
			fill_order_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_ORIGIN_X:   origin_x_q   <= pwdata[15:0];
				REG_ORIGIN_Y:   origin_y_q   <= pwdata[15:0];
				REG_BOX_WIDTH:  box_width_q  <= pwdata[SIZE_W-1:0];
				REG_BOX_HEIGHT: box_height_q <= pwdata[SIZE_W-1:0];
				REG_FILL_ORDER: fill_order_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ORIGIN_X:   prdata = {{16{origin_x_q[15]}}, origin_x_q};
			REG_ORIGIN_Y:   prdata = {{16{origin_y_q[15]}}, origin_y_q};
			REG_BOX_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, box_width_q};
			REG_BOX_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, box_height_q};
			REG_FILL_ORDER: prdata = {31'd0, fill_order_q};
			default:        prdata = '0;
		endcase
	end

	assign done    = done_q;
	assign status  = status_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result words in a row");

	a_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STAT_FILLED) |-> (pixel_x_q == '0 && pixel_y_q == '0))
		else $error("pixel set on a word that fills nothing");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_WALL || command == CMD_START || command == CMD_STEP))
		|=> busy)
		else $error("busy not raised after a command");

endmodule

`default_nettype wire

// ===== design/sf4c_cont.sv =====
`default_nettype none

module sf4c_cont (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sf4c_pkg::cont_ctrl_t     ctrl,
	output logic [sf4c_pkg::IDX_W-1:0]    pop_idx,
	output sf4c_pkg::cont_stat_t          stat
);
	import sf4c_pkg::*;

	logic [IDX_W-1:0] mem [CONT_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [IDX_W-1:0] rd_q;
	logic [PTR_W-1:0] rd_addr;
	logic             full;

	assign full    = (cnt_q == CNT_W'(CONT_DEPTH));
	assign rd_addr = ctrl.lifo ? (tail_q - PTR_W'(1)) : head_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && !ctrl.clear && !full) begin
			mem[tail_q] <= ctrl.push_idx;
		end
		if (ctrl.pop) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (ctrl.clear) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (ctrl.push) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				tail_q <= tail_q + PTR_W'(1);
				cnt_q  <= cnt_q + CNT_W'(1);
			end
		end else if (ctrl.pop) begin
			if (ctrl.lifo) begin
				tail_q <= tail_q - PTR_W'(1);
			end else begin
				head_q <= head_q + PTR_W'(1);
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign pop_idx       = rd_q;
	assign stat.empty    = (cnt_q == '0);
	assign stat.overflow = ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CONT_DEPTH))
		else $error("container count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pop && !ctrl.clear) |-> (cnt_q != '0))
		else $error("pop from empty container");

	a_ovf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push && !ctrl.clear && full) |=> ovf_q)
		else $error("dropped push did not raise overflow");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Seed fill testbench: commands go in through the start/busy channel, every
// report that the block strobes out on done is checked against a cycle-free
// prediction of the fill (wall bits, visited bits, pending container). The
// predictor steps once per accepted word and queues the report it expects.
module tb;
	import sf4c_pkg::*;

	// command 3 has no meaning; the block must drop it without a report
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	// cycles with no accepted word, report or register write before giving up
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [1:0]         command;
		logic [5:0]         cell_col;
		logic [5:0]         cell_row;
		logic               wall_bit;
		logic signed [15:0] seed_x;
		logic signed [15:0] seed_y;
	} fill_word_t;

	typedef struct {
		logic [2:0]         status;
		logic signed [16:0] pixel_x;
		logic signed [16:0] pixel_y;
	} fill_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic start = 1'b0;
	logic [1:0] command = CMD_WALL;
	logic [5:0] cell_col = '0;
	logic [5:0] cell_row = '0;
	logic wall_bit = 1'b0;
	logic signed [15:0] seed_x = '0;
	logic signed [15:0] seed_y = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;

	logic busy;
	logic done;
	logic [2:0] status;
	logic signed [16:0] pixel_x;
	logic signed [16:0] pixel_y;
	logic [31:0] prdata;
	logic pready;

	// predicted block state: box registers, both bitmaps, the pending container
	logic signed [15:0] box_org_x = '0;
	logic signed [15:0] box_org_y = '0;
	logic [6:0] box_cols_reg = 7'd64;
	logic [6:0] box_rows_reg = 7'd64;
	logic breadth_first = 1'b0;
	bit [GRID_W*GRID_H-1:0] wall_bits = '0;
	bit [GRID_W*GRID_H-1:0] visit_bits = '0;
	logic [IDX_W-1:0] frontier_cells [CONT_DEPTH];
	logic [PTR_W-1:0] frontier_head = '0;
	logic [PTR_W-1:0] frontier_tail = '0;
	int unsigned frontier_count = 0;
	bit frontier_spilled = 1'b0;

	fill_report_t fill_reports[$];
	int fault_count = 0;
	int words_sent = 0;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	seed_fill_4_connected dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.wall_bit(wall_bit),
		.seed_x(seed_x),
		.seed_y(seed_y),
		.done(done),
		.status(status),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// A size of 0 acts as 1, anything past the grid acts as the grid.
	function automatic int clamp_span(input logic [6:0] v, input int grid);
		if (v == 0)
			return 1;
		return (int'(v) > grid) ? grid : int'(v);
	endfunction

	// Drop the push and remember it when the container is full; the finished
	// report then turns into the overflow code until the next start.
	function automatic void frontier_push(input logic [IDX_W-1:0] grid_idx);
		if (frontier_count >= CONT_DEPTH) begin
			frontier_spilled = 1'b1;
			return;
		end
		frontier_cells[frontier_tail] = grid_idx;
		frontier_tail++;
		frontier_count++;
	endfunction

	function automatic void offer_neighbour(input int col, input int row);
		logic [IDX_W-1:0] grid_idx;
		grid_idx = IDX_W'(row * GRID_W + col);
		if (!visit_bits[grid_idx] && !wall_bits[grid_idx])
			frontier_push(grid_idx);
	endfunction

	// Step the fill for one accepted word; return 1 with the report it causes.
	function automatic bit predict_fill_step(input fill_word_t w, output fill_report_t r);
		int cols, rows, rx, ry, col, row;
		logic [IDX_W-1:0] grid_idx;
		cols = clamp_span(box_cols_reg, GRID_W);
		rows = clamp_span(box_rows_reg, GRID_H);
		r.status = STAT_STARTED;
		r.pixel_x = '0;
		r.pixel_y = '0;
		case (w.command)
		CMD_WALL: begin
			wall_bits[{w.cell_row, w.cell_col}] = w.wall_bit;
			return 1'b0;
		end
		CMD_START: begin
			rx = int'(w.seed_x) - int'(box_org_x);
			ry = int'(w.seed_y) - int'(box_org_y);
			// a seed off the box leaves the running fill alone
			if (rx < 0 || ry < 0 || rx >= cols || ry >= rows) begin
				r.status = STAT_OUTSIDE;
				return 1'b1;
			end
			visit_bits = '0;
			frontier_head = '0;
			frontier_tail = '0;
			frontier_count = 0;
			frontier_spilled = 1'b0;
			frontier_push(IDX_W'(ry * GRID_W + rx));
			return 1'b1;
		end
		CMD_STEP: begin
			if (frontier_count == 0) begin
				r.status = frontier_spilled ? STAT_OVF : STAT_DONE;
				return 1'b1;
			end
			// queue pops the oldest entry, stack the newest
			if (breadth_first) begin
				grid_idx = frontier_cells[frontier_head];
				frontier_head++;
			end else begin
				frontier_tail--;
				grid_idx = frontier_cells[frontier_tail];
			end
			frontier_count--;
			col = int'(grid_idx[COL_W-1:0]);
			row = int'(grid_idx[IDX_W-1:COL_W]);
			if (!visit_bits[grid_idx]) begin
				visit_bits[grid_idx] = 1'b1;
				r.status = STAT_FILLED;
				r.pixel_x = {box_org_x[15], box_org_x} + 17'(col);
				r.pixel_y = {box_org_y[15], box_org_y} + 17'(row);
			end else begin
				r.status = STAT_REVISIT;
			end
			// neighbours in the order +x, +y, -x, -y against the current box
			if (col + 1 < cols)
				offer_neighbour(col + 1, row);
			if (row + 1 < rows)
				offer_neighbour(col, row + 1);
			if (col > 0)
				offer_neighbour(col - 1, row);
			if (row > 0)
				offer_neighbour(col, row - 1);
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	// A report lives for exactly the cycle that ends at this edge; compare it
	// with the oldest expectation.
	always @(posedge clk) begin
		fill_report_t exp;
		if (arst_n && done) begin
			if (fill_reports.size() == 0) begin
				flag_mismatch($sformatf("report with nothing expected: status %0d x %0d y %0d",
					status, pixel_x, pixel_y));
			end else begin
				exp = fill_reports.pop_front();
				if (status !== exp.status || pixel_x !== exp.pixel_x || pixel_y !== exp.pixel_y)
					flag_mismatch($sformatf(
						"status %0d x %0d y %0d, expected status %0d x %0d y %0d",
						status, pixel_x, pixel_y, exp.status, exp.pixel_x, exp.pixel_y));
			end
		end
	end

	// Watchdog: give up when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Send one word and step the prediction at the edge that takes it. Start
	// stays high afterwards so the next word can follow at once; whoever
	// waits for anything else drops it first.
	task automatic send_word(input fill_word_t w);
		fill_report_t r;
		if (gaps_on && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		command <= w.command;
		cell_col <= w.cell_col;
		cell_row <= w.cell_row;
		wall_bit <= w.wall_bit;
		seed_x <= w.seed_x;
		seed_y <= w.seed_y;
		do @(posedge clk); while (busy);
		if (predict_fill_step(w, r))
			fill_reports.push_back(r);
		if (w.command != CMD_IGNORED)
			words_sent++;
	endtask

	// Fields a command does not use still toggle.
	function automatic fill_word_t random_word(input logic [1:0] cmd);
		fill_word_t w;
		w.command = cmd;
		w.cell_col = 6'($urandom);
		w.cell_row = 6'($urandom);
		w.wall_bit = 1'($urandom);
		w.seed_x = 16'($urandom);
		w.seed_y = 16'($urandom);
		return w;
	endfunction

	task automatic wall_at(input logic [5:0] col, input logic [5:0] row, input logic bit_val);
		fill_word_t w;
		w = random_word(CMD_WALL);
		w.cell_col = col;
		w.cell_row = row;
		w.wall_bit = bit_val;
		send_word(w);
	endtask

	task automatic start_fill(input logic signed [15:0] sx, input logic signed [15:0] sy);
		fill_word_t w;
		w = random_word(CMD_START);
		w.seed_x = sx;
		w.seed_y = sy;
		send_word(w);
	endtask

	task automatic advance();
		send_word(random_word(CMD_STEP));
	endtask

	// Drop start, wait for every expected report and for busy to fall, then
	// give a wall write that reports nothing time to finish.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (fill_reports.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup phase, access phase, then back to idle.
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_ORIGIN_X:   box_org_x = value[15:0];
		REG_ORIGIN_Y:   box_org_y = value[15:0];
		REG_BOX_WIDTH:  box_cols_reg = value[6:0];
		REG_BOX_HEIGHT: box_rows_reg = value[6:0];
		REG_FILL_ORDER: breadth_first = value[0];
		default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_box(input logic signed [15:0] ox, input logic signed [15:0] oy,
		input logic [6:0] cols, input logic [6:0] rows, input logic order);
		wait_idle();
		cfg_write(REG_ORIGIN_X, {16'h0, ox});
		cfg_write(REG_ORIGIN_Y, {16'h0, oy});
		cfg_write(REG_BOX_WIDTH, {25'h0, cols});
		cfg_write(REG_BOX_HEIGHT, {25'h0, rows});
		cfg_write(REG_FILL_ORDER, {31'h0, order});
	endtask

	function automatic logic [6:0] pick_span();
		int r;
		r = $urandom_range(19);
		case (r)
		0: return 7'd0;
		1: return 7'd127;
		2: return 7'd64;
		3: return 7'($urandom_range(7, 70));
		default: return 7'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_origin();
		int r;
		r = $urandom_range(9);
		case (r)
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	// Advance until the container drains or the cap is hit, then ask once or
	// twice more to see the finished report. With reshape set, pause after
	// two steps and change one register while entries are still pending.
	task automatic run_fill(input int cap, input bit reshape);
		int n;
		n = 0;
		while (frontier_count != 0 && n < cap) begin
			if (reshape && n == 2) begin
				wait_idle();
				case ($urandom_range(4))
				0: cfg_write(REG_ORIGIN_X, {16'h0, pick_origin()});
				1: cfg_write(REG_ORIGIN_Y, {16'h0, pick_origin()});
				2: cfg_write(REG_BOX_WIDTH, {25'h0, pick_span()});
				3: cfg_write(REG_BOX_HEIGHT, {25'h0, pick_span()});
				default: cfg_write(REG_FILL_ORDER, {31'h0, !breadth_first});
				endcase
			end
			advance();
			n++;
		end
		if (frontier_count == 0)
			repeat ($urandom_range(1, 2)) advance();
	endtask

	// One well-formed fill with random geometry, walls and seed, with the
	// odd ignored word, stray start or cut-short fill mixed in.
	task automatic random_phase();
		logic signed [15:0] ox, oy;
		int cols, rows, cap;
		ox = pick_origin();
		oy = pick_origin();
		set_box(ox, oy, pick_span(), pick_span(), 1'($urandom));
		cols = clamp_span(box_cols_reg, GRID_W);
		rows = clamp_span(box_rows_reg, GRID_H);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(3) != 0)
				wall_at(6'($urandom_range(cols - 1)), 6'($urandom_range(rows - 1)),
					$urandom_range(9) < 7);
			else
				wall_at(6'($urandom), 6'($urandom), 1'($urandom));
		end
		if ($urandom_range(9) == 0)
			send_word(random_word(CMD_IGNORED));
		if ($urandom_range(9) == 0)
			start_fill(16'($urandom), 16'($urandom));
		start_fill(ox + 16'($urandom_range(cols - 1)), oy + 16'($urandom_range(rows - 1)));
		// big boxes would take thousands of steps; cut them off
		cap = ($urandom_range(9) == 0) ? $urandom_range(0, 3) : 80;
		run_fill(cap, $urandom_range(7) == 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Advance before any start, and a word with the unused command.
	task automatic test_empty_container();
		advance();
		send_word(random_word(CMD_IGNORED));
		advance();
	endtask

	// Walled-in single cells at the far and near grid corners. The far one
	// is filled after the origin moves to its top, which puts the reported
	// pixel above what a 16-bit signed value can hold.
	task automatic test_grid_corners();
		wall_at(6'd62, 6'd63, 1'b1);
		wall_at(6'd63, 6'd62, 1'b1);
		start_fill(16'sd63, 16'sd63);
		wait_idle();
		cfg_write(REG_ORIGIN_X, 32'h7FFF);
		cfg_write(REG_ORIGIN_Y, 32'h7FFF);
		run_fill(4, 1'b0);
		wall_at(6'd1, 6'd0, 1'b1);
		wall_at(6'd0, 6'd1, 1'b1);
		wait_idle();
		cfg_write(REG_ORIGIN_X, 32'h8000);
		cfg_write(REG_ORIGIN_Y, 32'h8000);
		start_fill(16'sh8000, 16'sh8000);
		run_fill(4, 1'b0);
	endtask

	// Width 0 acts as one column and height 127 as the full grid; probe the seed
	// check just past the low column edge and the high row edge, seed inside the
	// box, then shrink the box and switch to the queue while entries are pending.
	task automatic test_box_edges();
		set_box(16'sh7FFF, 16'sh8000, 7'd0, 7'd127, 1'b0);
		start_fill(16'sh7FFE, 16'sh803F);
		start_fill(16'sh7FFF, 16'sh8040);
		start_fill(16'($urandom), 16'($urandom));
		start_fill(16'sh7FFF, 16'sh803F);
		advance();
		wait_idle();
		cfg_write(REG_BOX_HEIGHT, 32'd1);
		cfg_write(REG_FILL_ORDER, 32'd1);
		advance();
		advance();
	endtask

	// A 2 x 2 box filled depth first pops its last cell twice.
	task automatic test_revisit();
		set_box(16'sd0, 16'sd0, 7'd2, 7'd2, 1'b0);
		wall_at(6'd1, 6'd0, 1'b0);
		wall_at(6'd0, 6'd1, 1'b0);
		start_fill(16'sd0, 16'sd0);
		run_fill(16, 1'b0);
	endtask

	task automatic test_random_fills();
		gaps_on = 1'b1;
		while (words_sent < 560)
			random_phase();
	endtask

	// Long stretch with start held high whenever a word is ready.
	task automatic test_back_to_back();
		int target;
		target = words_sent + 140;
		gaps_on = 1'b0;
		while (words_sent < target)
			random_phase();
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_container();
		test_grid_corners();
		test_box_edges();
		test_revisit();
		test_random_fills();
		test_back_to_back();
		wait_idle();
		repeat (16) @(posedge clk);
		if (fill_reports.size() != 0)
			flag_mismatch($sformatf("%0d reports never arrived", fill_reports.size()));
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
